>>> sv/assert_macros.svh
// Assertion macros used by the keyer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/mmk_pkg.sv
// Types, register map and message tables for the Morse message keyer.
package mmk_pkg;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_UNIT     = 2'd0,
        REG_POLL     = 2'd1,
        REG_DEBOUNCE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MSG_NONE = 2'd0,
        MSG_SOS  = 2'd1,
        MSG_YES  = 2'd2,
        MSG_NO   = 2'd3
    } msg_t;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [9:0]  poll_ticks;
        logic [9:0]  debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic       led_on;
        logic [1:0] active_message;
    } res_t;

    localparam logic [15:0] UNIT_RST     = 16'd200;
    localparam logic [9:0]  POLL_RST     = 10'd20;
    localparam logic [9:0]  DEBOUNCE_RST = 10'd20;

    // letters: 0 S, 1 O, 2 Y, 3 E, 4 N
    function automatic logic [2:0] letter_len(input logic [2:0] l);
        logic [2:0] r;
        case (l)
            3'd0:    r = 3'd3;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd2;
            default: r = 3'd3;
        endcase
        return r;
    endfunction

    // bit i set: symbol i is a dash
    function automatic logic [3:0] letter_bits(input logic [2:0] l);
        logic [3:0] r;
        case (l)
            3'd1:    r = 4'h7;
            3'd2:    r = 4'hD;
            3'd4:    r = 4'h1;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] msg_row(input logic [1:0] msg);
        logic [1:0] m;
        m = msg - 2'd1;
        if (m > 2'd2)
            m = 2'd0;
        return m;
    endfunction

    function automatic logic [1:0] msg_len(input logic [1:0] msg);
        return (msg_row(msg) == 2'd2) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [2:0] msg_letter(input logic [1:0] msg, input logic [1:0] pos);
        logic [1:0] p;
        logic [2:0] r;
        p = (pos == 2'd3) ? 2'd0 : pos;
        r = 3'd0;
        case (msg_row(msg))
            2'd0:    r = (p == 2'd1) ? 3'd1 : 3'd0;
            2'd1:    r = (p == 2'd0) ? 3'd2 : ((p == 2'd1) ? 3'd3 : 3'd0);
            default: r = (p == 2'd0) ? 3'd4 : ((p == 2'd1) ? 3'd1 : 3'd0);
        endcase
        return r;
    endfunction

endpackage

>>> sv/morse_message_keyer.sv
// Morse message keyer top level: tick input register, sequencer, result register.
//
//  channel  dir   beat                       payload
//  s_*      in    one millisecond tick       key levels
//  m_*      out   one result per tick        LED level, active message
//  apb      in    register write or read     unit, poll, debounce ticks
//
// One tick per cycle sustained while the result side is not stalled.
// A tick is registered, then the sequencer updates state and the result register.
// Rate is set by the sequencer, which updates its state once per advancing tick.
// Reset returns to idle polling with the valid flags, sequencer and configuration registers at their defaults.
// A stalled result holds the result register; one more tick may wait in the input register.
`include "assert_macros.svh"

module morse_message_keyer
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] key_up_pressed, [1] key1_pressed, [2] key0_pressed
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] led_on, [2:1] active_message
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mmk_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    mmk_pkg::cfg_t cfg;
    mmk_pkg::res_t res;

    logic          s1_valid_reg, s1_valid_next;
    logic [2:0]    s1_keys_reg;
    logic          out_valid_reg, out_valid_next;
    mmk_pkg::res_t out_reg;
    logic          adv;
    logic          take;

    mmk_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mmk_core #(.TIMER_BITS(TIMER_BITS)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .keys  (s1_keys_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign adv      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign take     = s_tvalid && s_tready;

    assign s1_valid_next  = take ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.active_message, out_reg.led_on};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_keys_reg <= s_tdata[2:0];
        if (adv)
            out_reg <= res;
    end

    `ASSERT_IMPLY(a_led_has_msg, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[2:1] != 2'd0)
    `ASSERT_IMPLY(a_stall_has_item, clk, rst_n, !s_tready, s1_valid_reg && out_valid_reg)
    `ASSERT_NEXT(a_take_loads, clk, rst_n, s_tvalid && s_tready, s1_valid_reg)
    `ASSERT_NEXT(a_adv_shows, clk, rst_n, adv, m_tvalid)

endmodule

>>> sv/mmk_cfg.sv
// APB register file for unit, poll and debounce intervals.
module mmk_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mmk_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mmk_pkg::cfg_t               cfg
);

    mmk_pkg::cfg_t    cfg_reg;
    mmk_pkg::cfg_t    cfg_next;
    mmk_pkg::reg_idx_t idx;

    assign idx    = mmk_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                mmk_pkg::REG_UNIT:     cfg_next.unit_ticks     = pwdata[15:0];
                mmk_pkg::REG_POLL:     cfg_next.poll_ticks     = pwdata[9:0];
                mmk_pkg::REG_DEBOUNCE: cfg_next.debounce_ticks = pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mmk_pkg::REG_UNIT:     prdata = {16'd0, cfg_reg.unit_ticks};
            mmk_pkg::REG_POLL:     prdata = {22'd0, cfg_reg.poll_ticks};
            mmk_pkg::REG_DEBOUNCE: prdata = {22'd0, cfg_reg.debounce_ticks};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks     <= mmk_pkg::UNIT_RST;
            cfg_reg.poll_ticks     <= mmk_pkg::POLL_RST;
            cfg_reg.debounce_ticks <= mmk_pkg::DEBOUNCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/mmk_core.sv
// Keyer sequencer: key polling, debounce, symbol timing and release wait.
module mmk_core
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [2:0]     keys,
    input  mmk_pkg::cfg_t  cfg,
    output mmk_pkg::res_t  res
);

    localparam int CW = (TIMER_BITS > 10) ? TIMER_BITS : 10;
    localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_MARK     = 3'd2,
        PH_SPACE    = 3'd3,
        PH_LGAP     = 3'd4,
        PH_MGAP     = 3'd5,
        PH_RELEASE  = 3'd6
    } phase_t;

    function automatic logic [CW-1:0] clamp(input logic [15:0] t);
        logic [32:0] w;
        w = {17'd0, t};
        if (w == 33'd0)
            w = 33'd1;
        if (w > TMAX)
            w = TMAX;
        return w[CW-1:0];
    endfunction

    phase_t        phase_reg,  phase_next;
    logic [CW-1:0] wait_reg,   wait_next;
    logic [2:0]    units_reg,  units_next;
    logic [1:0]    msg_reg,    msg_next;
    logic [1:0]    letter_reg, letter_next;
    logic [2:0]    sym_reg,    sym_next;
    logic [1:0]    kut_reg,    kut_next;
    logic          led_reg,    led_next;

    logic          act;
    logic          do_scan;
    logic [1:0]    scan_from;
    logic          do_sym;
    logic          found;
    logic [1:0]    found_k;
    logic [2:0]    cand;
    logic [2:0]    cur_l;
    logic [3:0]    dash_bits;
    logic [2:0]    lp1;

    always_comb
    begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        units_next  = units_reg;
        msg_next    = msg_reg;
        letter_next = letter_reg;
        sym_next    = sym_reg;
        kut_next    = kut_reg;
        led_next    = led_reg;
        act         = 1'b1;
        do_scan     = 1'b0;
        scan_from   = 2'd0;
        do_sym      = 1'b0;
        found       = 1'b0;
        found_k     = 2'd0;
        cand        = 3'd0;
        cur_l       = 3'd0;
        dash_bits   = 4'd0;
        lp1         = 3'd0;

        if (wait_reg != '0)
        begin
            wait_next = wait_reg - CW'(1);
            if (wait_next == '0 && units_reg > 3'd1)
            begin
                units_next = units_reg - 3'd1;
                wait_next  = clamp(cfg.unit_ticks);
            end
            if (wait_next != '0)
                act = 1'b0;
        end

        if (act)
        begin
            unique case (phase_reg)
                PH_DEBOUNCE:
                begin
                    if (kut_reg != 2'd3 && keys[kut_reg])
                    begin
                        msg_next    = kut_reg + 2'd1;
                        letter_next = 2'd0;
                        sym_next    = 3'd0;
                        do_sym      = 1'b1;
                    end
                    else
                    begin
                        do_scan   = 1'b1;
                        scan_from = kut_reg + 2'd1;
                    end
                end
                PH_MARK:
                begin
                    led_next   = 1'b0;
                    phase_next = PH_SPACE;
                    sym_next   = sym_reg + 3'd1;
                    wait_next  = clamp(cfg.unit_ticks);
                    units_next = 3'd1;
                end
                PH_SPACE:
                begin
                    cur_l = mmk_pkg::msg_letter(msg_reg, letter_reg);
                    lp1   = {1'b0, letter_reg} + 3'd1;
                    if (sym_reg < mmk_pkg::letter_len(cur_l))
                    begin
                        do_sym = 1'b1;
                    end
                    else if (lp1 < {1'b0, mmk_pkg::msg_len(msg_reg)})
                    begin
                        phase_next = PH_LGAP;
                        wait_next  = clamp(cfg.unit_ticks);
                        units_next = 3'd2;
                    end
                    else
                    begin
                        phase_next = PH_MGAP;
                        wait_next  = clamp(cfg.unit_ticks);
                        units_next = 3'd7;
                    end
                end
                PH_LGAP:
                begin
                    letter_next = letter_reg + 2'd1;
                    sym_next    = 3'd0;
                    do_sym      = 1'b1;
                end
                PH_MGAP, PH_RELEASE:
                begin
                    msg_next = mmk_pkg::MSG_NONE;
                    if (kut_reg != 2'd3 && keys[kut_reg])
                    begin
                        phase_next = PH_RELEASE;
                        wait_next  = clamp({6'd0, cfg.poll_ticks});
                        units_next = 3'd1;
                    end
                    else
                    begin
                        do_scan = 1'b1;
                    end
                end
                default:
                begin
                    do_scan = 1'b1;
                end
            endcase
        end

        if (do_scan)
        begin
            cand[0] = keys[0] && (scan_from == 2'd0);
            cand[1] = keys[1] && (scan_from <= 2'd1);
            cand[2] = keys[2] && (scan_from <= 2'd2);
            found   = (cand != 3'd0);
            found_k = cand[0] ? 2'd0 : (cand[1] ? 2'd1 : 2'd2);
            if (!found)
            begin
                phase_next = PH_IDLE;
                kut_next   = 2'd0;
                wait_next  = clamp({6'd0, cfg.poll_ticks});
                units_next = 3'd1;
            end
            else if (cfg.debounce_ticks == 10'd0)
            begin
                kut_next    = found_k;
                msg_next    = found_k + 2'd1;
                letter_next = 2'd0;
                sym_next    = 3'd0;
                do_sym      = 1'b1;
            end
            else
            begin
                phase_next = PH_DEBOUNCE;
                kut_next   = found_k;
                wait_next  = CW'(cfg.debounce_ticks);
                units_next = 3'd1;
            end
        end

        if (do_sym)
        begin
            dash_bits  = mmk_pkg::letter_bits(mmk_pkg::msg_letter(msg_next, letter_next));
            phase_next = PH_MARK;
            led_next   = 1'b1;
            wait_next  = clamp(cfg.unit_ticks);
            units_next = dash_bits[sym_next[1:0]] ? 3'd3 : 3'd1;
        end
    end

    assign res.led_on = led_next;
    assign res.active_message = (phase_next == PH_MARK || phase_next == PH_SPACE ||
                                 phase_next == PH_LGAP || phase_next == PH_MGAP)
                                ? msg_next : mmk_pkg::MSG_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            wait_reg   <= '0;
            units_reg  <= 3'd0;
            msg_reg    <= mmk_pkg::MSG_NONE;
            letter_reg <= 2'd0;
            sym_reg    <= 3'd0;
            kut_reg    <= 2'd0;
            led_reg    <= 1'b0;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            units_reg  <= units_next;
            msg_reg    <= msg_next;
            letter_reg <= letter_next;
            sym_reg    <= sym_next;
            kut_reg    <= kut_next;
            led_reg    <= led_next;
        end
    end

endmodule

>>> tb/sv/morse_keyer_checker.sv
// Checker for the Morse message keyer: predicts every tick's result and compares it.
`timescale 1ns / 100ps

module morse_keyer_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] key_up_pressed, [1] key1_pressed, [2] key0_pressed
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,   // [0] led_on, [2:1] active_message
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mmk_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          errors,
    output int                          outstanding,
    output int                          results_seen,
    output int                          messages_keyed
);
    import mmk_pkg::*;

    typedef enum logic [2:0] {
        KS_IDLE,
        KS_DEBOUNCE,
        KS_MARK,
        KS_SPACE,
        KS_LETTER_GAP,
        KS_WORD_GAP,
        KS_RELEASE
    } keyer_state_t;

    localparam int LT_S = 0;
    localparam int LT_O = 1;
    localparam int LT_Y = 2;
    localparam int LT_E = 3;
    localparam int LT_N = 4;

    logic [15:0]  unit_cfg;
    logic [9:0]   poll_cfg;
    logic [9:0]   deb_cfg;

    keyer_state_t kstate;
    logic [15:0]  dly_left;
    int           units_rem;
    logic [1:0]   msg_cur;
    logic [1:0]   letter_idx;
    logic [2:0]   symbol_idx;
    logic [1:0]   probe_key;
    logic         lamp;

    res_t lamp_expect_q[$];

    function automatic int glyph_length(input int g);
        int n;
        case (g)
            LT_Y:    n = 4;
            LT_E:    n = 1;
            LT_N:    n = 2;
            default: n = 3;
        endcase
        return n;
    endfunction

    // bit i set: symbol i is a dash
    function automatic logic [3:0] glyph_dashes(input int g);
        logic [3:0] d;
        case (g)
            LT_O:    d = 4'b0111;
            LT_Y:    d = 4'b1101;
            LT_N:    d = 4'b0001;
            default: d = 4'b0000;
        endcase
        return d;
    endfunction

    // no message selected falls back to the SOS row
    function automatic int message_row();
        int row;
        case (msg_cur)
            MSG_YES: row = 1;
            MSG_NO:  row = 2;
            default: row = 0;
        endcase
        return row;
    endfunction

    function automatic int current_glyph();
        int p;
        int g;
        p = (letter_idx == 2'd3) ? 0 : int'(letter_idx);
        case (message_row())
            0:       g = (p == 1) ? LT_O : LT_S;
            1:       g = (p == 0) ? LT_Y : ((p == 1) ? LT_E : LT_S);
            default: g = (p == 0) ? LT_N : ((p == 1) ? LT_O : LT_S);
        endcase
        return g;
    endfunction

    function automatic logic [15:0] nonzero_ticks(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    function automatic void load_delay(input logic [15:0] t, input int units);
        dly_left  = nonzero_ticks(t);
        units_rem = units;
    endfunction

    function automatic bit key_down(input logic [2:0] keys, input int k);
        return (k < 3) && (keys[k] == 1'b1);
    endfunction

    function automatic void begin_symbol();
        logic [3:0] dashes;
        dashes = glyph_dashes(current_glyph());
        kstate = KS_MARK;
        lamp   = 1'b1;
        load_delay(unit_cfg, dashes[symbol_idx[1:0]] ? 3 : 1);
    endfunction

    function automatic void begin_message(input logic [1:0] k);
        probe_key  = k;
        msg_cur    = k + 2'd1;
        letter_idx = 2'd0;
        symbol_idx = 3'd0;
        messages_keyed++;
        begin_symbol();
    endfunction

    // priority scan from key 'first'; up key is index 0
    function automatic void poll_keys(input logic [2:0] keys, input int first);
        int k;
        for (k = first; k < 3; k++)
        begin
            if (key_down(keys, k))
            begin
                if (deb_cfg == 10'd0)
                    begin_message(k[1:0]);
                else
                begin
                    kstate    = KS_DEBOUNCE;
                    probe_key = k[1:0];
                    dly_left  = {6'd0, deb_cfg};
                    units_rem = 1;
                end
                return;
            end
        end
        kstate    = KS_IDLE;
        probe_key = 2'd0;
        load_delay({6'd0, poll_cfg}, 1);
    endfunction

    function automatic void release_or_poll(input logic [2:0] keys);
        msg_cur = MSG_NONE;
        if (key_down(keys, probe_key))
        begin
            kstate = KS_RELEASE;
            load_delay({6'd0, poll_cfg}, 1);
        end
        else
            poll_keys(keys, 0);
    endfunction

    function automatic void keyer_tick(input logic [2:0] keys, output res_t r);
        logic fire;
        fire = 1'b1;
        if (dly_left != 16'd0)
        begin
            dly_left = dly_left - 16'd1;
            if (dly_left == 16'd0 && units_rem > 1)
            begin
                units_rem = units_rem - 1;
                dly_left  = nonzero_ticks(unit_cfg);
            end
            if (dly_left != 16'd0)
                fire = 1'b0;
        end
        if (fire)
        begin
            case (kstate)
                KS_DEBOUNCE:
                    if (key_down(keys, probe_key))
                        begin_message(probe_key);
                    else
                        poll_keys(keys, int'(probe_key) + 1);
                KS_MARK:
                begin
                    lamp       = 1'b0;
                    kstate     = KS_SPACE;
                    symbol_idx = symbol_idx + 3'd1;
                    load_delay(unit_cfg, 1);
                end
                KS_SPACE:
                    if (int'(symbol_idx) < glyph_length(current_glyph()))
                        begin_symbol();
                    else if (int'(letter_idx) + 1 < ((message_row() == 2) ? 2 : 3))
                    begin
                        kstate = KS_LETTER_GAP;
                        load_delay(unit_cfg, 2);
                    end
                    else
                    begin
                        kstate = KS_WORD_GAP;
                        load_delay(unit_cfg, 7);
                    end
                KS_LETTER_GAP:
                begin
                    letter_idx = letter_idx + 2'd1;
                    symbol_idx = 3'd0;
                    begin_symbol();
                end
                KS_WORD_GAP, KS_RELEASE:
                    release_or_poll(keys);
                default:
                    poll_keys(keys, 0);
            endcase
        end
        r.led_on         = lamp;
        r.active_message = (kstate >= KS_MARK && kstate <= KS_WORD_GAP) ? msg_cur : MSG_NONE;
    endfunction

    function automatic logic [31:0] register_value(input logic [mmk_pkg::ADDR_W-1:0] a);
        logic [31:0] v;
        case (a)
            {REG_UNIT, 2'b00}:     v = {16'd0, unit_cfg};
            {REG_POLL, 2'b00}:     v = {22'd0, poll_cfg};
            {REG_DEBOUNCE, 2'b00}: v = {22'd0, deb_cfg};
            default:               v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     errors, $time, what, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        if (!rst_n)
        begin
            unit_cfg   = UNIT_RST;
            poll_cfg   = POLL_RST;
            deb_cfg    = DEBOUNCE_RST;
            kstate     = KS_IDLE;
            dly_left   = 16'd0;
            units_rem  = 0;
            msg_cur    = MSG_NONE;
            letter_idx = 2'd0;
            symbol_idx = 3'd0;
            probe_key  = 2'd0;
            lamp       = 1'b0;
            lamp_expect_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (lamp_expect_q.size() == 0)
                    flag_mismatch("result beat with nothing expected", 32'd0, {24'd0, m_tdata});
                else
                begin
                    want = lamp_expect_q.pop_front();
                    if (m_tdata[0] !== want.led_on)
                        flag_mismatch("led_on", {31'd0, want.led_on}, {31'd0, m_tdata[0]});
                    if (m_tdata[2:1] !== want.active_message)
                        flag_mismatch("active_message", {30'd0, want.active_message},
                                      {30'd0, m_tdata[2:1]});
                end
            end

            if (s_tvalid && s_tready)
            begin
                keyer_tick(s_tdata[2:0], want);
                lamp_expect_q.push_back(want);
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr)
                        {REG_UNIT, 2'b00}:     unit_cfg = pwdata[15:0];
                        {REG_POLL, 2'b00}:     poll_cfg = pwdata[9:0];
                        {REG_DEBOUNCE, 2'b00}: deb_cfg  = pwdata[9:0];
                        default: ;
                    endcase
                end
                else if (prdata !== register_value(paddr))
                    flag_mismatch("register readback", register_value(paddr), prdata);
            end

            outstanding <= lamp_expect_q.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Keyer testbench top: clock, reset, key stimulus, register settings, idling and verdict.
`timescale 1ns / 100ps

module testbench;
    import mmk_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    localparam logic [2:0] KEYS_NONE = 3'b000;
    localparam logic [2:0] KEY_UP    = 3'b001;
    localparam logic [2:0] KEY_ONE   = 3'b010;
    localparam logic [2:0] KEY_ZERO  = 3'b100;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;   // [0] key_up_pressed, [1] key1_pressed, [2] key0_pressed
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;            // [0] led_on, [2:1] active_message
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_W-1:0]    paddr     = '0;
    logic [31:0]          pwdata    = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    int gap_pct       = 0;
    int stall_pct     = 0;
    int ticks_sent    = 0;
    int settings_used = 1;
    int quiet_cycles  = 0;
    int mismatches;
    int pending;
    int compared;
    int keyed;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    morse_message_keyer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    morse_keyer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .errors         (mismatches),
        .outstanding    (pending),
        .results_seen   (compared),
        .messages_keyed (keyed)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_tick(input logic [2:0] keys);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, keys};
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // leaves psel high; the caller closes the access sequence
    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic reconfigure(input logic [31:0] unit, input logic [31:0] poll,
                               input logic [31:0] deb);
        drain_results();
        repeat (4) @(posedge clk);
        apb_access(REG_UNIT, 1'b1, unit);
        apb_access(REG_POLL, 1'b1, poll);
        apb_access(REG_DEBOUNCE, 1'b1, deb);
        apb_access(REG_UNIT, 1'b0, 32'd0);
        apb_access(REG_POLL, 1'b0, 32'd0);
        apb_access(REG_DEBOUNCE, 1'b0, 32'd0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // mostly held presses long enough to key a whole message, then releases and bounce
    task automatic key_episodes(input int n, input int unit);
        int done;
        int hold;
        int roll;
        int i;
        logic [2:0] keys;
        done = 0;
        while (done < n)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                if ($urandom_range(3) == 0)
                    keys = 3'($urandom_range(1, 7));
                else
                    keys = 3'b001 << $urandom_range(2);
                hold = $urandom_range(4, 40 * unit + 40);
            end
            else if (roll < 80)
            begin
                keys = KEYS_NONE;
                hold = $urandom_range(1, 25);
            end
            else
            begin
                keys = 3'($urandom_range(7));
                hold = $urandom_range(1, 3);
            end
            for (i = 0; i < hold && done < n; i++)
            begin
                send_tick(keys);
                done++;
                if (ticks_sent % 157 == 0)
                    drain_results();
            end
        end
    endtask

    task automatic run_phase(input int unit, input int poll, input int deb,
                             input int gap, input int stall, input int n);
        reconfigure(unit, poll, deb);
        gap_pct   = gap;
        stall_pct = stall;
        key_episodes(n, (unit == 0) ? 1 : unit);
    endtask

    initial
    begin : stimulus
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: every key combination once
        for (k = 0; k < 8; k++)
            send_tick(3'(k));

        // zero unit, zero poll, zero debounce
        reconfigure(32'd0, 32'd0, 32'd0);
        repeat (4) send_tick(KEY_ZERO);
        repeat (2) send_tick(KEYS_NONE);
        repeat (3) send_tick(KEY_UP | KEY_ZERO);
        repeat (2) send_tick(KEY_ONE);

        // up key bounces off during debounce, key one is tried next
        reconfigure(32'd1, 32'd1, 32'd2);
        send_tick(KEY_UP | KEY_ONE);
        repeat (3) send_tick(KEY_ONE);
        repeat (2) send_tick(KEYS_NONE);

        run_phase(1, 1, 1, 0, 0, 220);
        run_phase(2, 3, 0, 63, 0, 220);
        run_phase(1, 2, 3, 0, 63, 220);
        run_phase(3, 1, 2, 27, 27, 220);
        run_phase(0, 0, 0, 0, 0, 160);
        run_phase(4, 5, 7, 27, 27, 140);
        // full-scale registers, upper write bits set
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 63, 50);

        drain_results();
        repeat (8) @(posedge clk);
        $display("%0d key ticks driven, %0d result beats compared, %0d messages keyed",
                 ticks_sent, compared, keyed);
        $display("%0d register settings, zero and full-scale included, under four idling mixes",
                 settings_used);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
